// ----- hdl/binary_trie_ip_lookup_top_assert.svh -----
// Assertion macros used by the binary trie lookup walker.
`ifndef BINARY_TRIE_IP_LOOKUP_TOP_ASSERT_SVH
`define BINARY_TRIE_IP_LOOKUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BTL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in binary trie lookup");
// Next-cycle implication, disabled during reset.
`define BTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in binary trie lookup");
`else
`define BTL_ASSERT_NOW(label, clk, rst, ante, cons)
`define BTL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/btl_pkg.sv -----
// Types, codes and helper functions for the binary trie IP lookup block.
`timescale 1ns / 1ps
`default_nettype none
package btl_pkg;

  // Operation codes of an input beat.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic REG_RECORD_SIZE = 1'b0;
  localparam logic REG_NODE_COUNT  = 1'b1;

  // Record size modes; the reserved code behaves as 32-bit records.
  localparam logic [1:0] MODE_24 = 2'd0;
  localparam logic [1:0] MODE_28 = 2'd1;
  localparam logic [1:0] MODE_32 = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  // Bit positions in the IPv4-mapped IPv6 address.
  localparam logic [6:0] MAP_ONES_FIRST = 7'd80;
  localparam logic [6:0] MAP_IP_FIRST   = 7'd96;
  localparam logic [6:0] MAP_LAST_BIT   = 7'd127;

  localparam logic [4:0] SUM_LAST_BIT = 5'd31;

  typedef struct packed {
    logic        op;
    logic [13:0] node_index;
    logic [63:0] node_bytes;
    logic [31:0] ip_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] record_value;
    logic [31:0] data_offset;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SUM
  } walk_state_t;

  // Node store access from the walker.
  typedef struct packed {
    logic        we;
    logic [13:0] waddr;
    logic [63:0] wdata;
    logic [14:0] raddr;
  } st_req_t;

  typedef struct packed {
    logic [63:0] rdata;
    logic        oor;
  } st_rsp_t;

  // Serial adder request and response.
  typedef struct packed {
    logic        go;
    logic [31:0] rec;
    logic [17:0] addend;
  } off_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] sum;
  } off_rsp_t;

  // Pulls the left or right record out of a raw node word.
  function automatic logic [31:0] pick_record(logic [63:0] w, logic [1:0] mode,
                                              logic right);
    logic [31:0] r;
    case (mode)
      MODE_24: r = right ? {8'd0, w[39:16]} : {8'd0, w[63:40]};
      MODE_28: r = right ? {4'd0, w[35:8]} : {4'd0, w[63:36]};
      default: r = right ? w[31:0] : w[63:32];
    endcase
    return r;
  endfunction

  // Node count times (node bytes - 1): the offset is record plus this value.
  function automatic logic [17:0] leaf_base(logic [14:0] nc, logic [1:0] mode);
    logic [2:0] m;
    case (mode)
      MODE_24: m = 3'd5;
      MODE_28: m = 3'd6;
      default: m = 3'd7;
    endcase
    return {3'd0, nc} * {15'd0, m};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/btl_node_store.sv -----
// Node store memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module btl_node_store #(
  parameter int NODES = 16384
) (
  input  wire               clk,
  input  btl_pkg::st_req_t  req,
  output btl_pkg::st_rsp_t  rsp
);
  import btl_pkg::*;

  localparam int AW = $clog2(NODES);

  logic [63:0] mem [NODES];
  logic [63:0] rdata;
  logic        oor;

  // Writes beyond the store are dropped; reads beyond it are flagged.
  always_ff @(posedge clk) begin
    if (req.we && (32'(req.waddr) < 32'(NODES))) begin
      mem[AW'(req.waddr)] <= req.wdata;
    end
    rdata <= mem[AW'(req.raddr)];
    oor   <= !(32'(req.raddr) < 32'(NODES));
  end

  assign rsp.rdata = rdata;
  assign rsp.oor   = oor;

endmodule
`default_nettype wire

// ----- hdl/btl_offset_unit.sv -----
// Bit-serial adder that forms the data offset of a leaf record.
`timescale 1ns / 1ps
`default_nettype none
module btl_offset_unit (
  input  wire                clk,
  input  wire                rst,
  input  btl_pkg::off_req_t  req,
  output btl_pkg::off_rsp_t  rsp
);
  import btl_pkg::*;

  logic        active;
  logic [4:0]  cnt;
  logic [31:0] a_sr;
  logic [31:0] b_sr;
  logic [31:0] sum_sr;
  logic        carry;
  logic        done;
  logic        s_bit;
  logic        c_bit;

  // One full adder, fed from the low ends of the operand shift registers.
  assign s_bit = a_sr[0] ^ b_sr[0] ^ carry;
  assign c_bit = (a_sr[0] & b_sr[0]) | (a_sr[0] & carry) | (b_sr[0] & carry);

  // Control: one sum bit per cycle, done pulses after the top bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == SUM_LAST_BIT);
      if (req.go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 5'd1;
        if (cnt == SUM_LAST_BIT) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers, least significant bit first.
  always_ff @(posedge clk) begin
    if (req.go) begin
      a_sr  <= req.rec;
      b_sr  <= {14'd0, req.addend};
      carry <= 1'b0;
    end else if (active) begin
      a_sr   <= {1'b0, a_sr[31:1]};
      b_sr   <= {1'b0, b_sr[31:1]};
      sum_sr <= {s_bit, sum_sr[31:1]};
      carry  <= c_bit;
    end
  end

  assign rsp.done = done;
  assign rsp.sum  = sum_sr;

endmodule
`default_nettype wire

// ----- hdl/btl_walker.sv -----
// Sequencer that walks the trie one address bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_trie_ip_lookup_top_assert.svh"
module btl_walker (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  btl_pkg::in_item_t  request,
  input  wire [1:0]          record_size_mode,
  input  wire [14:0]         num_nodes,
  output btl_pkg::st_req_t   st_req,
  input  btl_pkg::st_rsp_t   st_rsp,
  output btl_pkg::off_req_t  off_req,
  input  btl_pkg::off_rsp_t  off_rsp,
  output logic               done,
  output btl_pkg::out_item_t result
);
  import btl_pkg::*;

  walk_state_t state, state_next;
  logic [6:0]  bit_cnt, bit_cnt_next;
  logic [31:0] ip_sr, ip_sr_next;
  logic [31:0] rec_hold, rec_hold_next;
  logic        done_next;
  out_item_t   result_next;

  logic        accept;
  logic        cur_bit;
  logic [31:0] nc32;
  logic [31:0] rec;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign nc32   = {17'd0, num_nodes};

  // Address bit under the walk: 80 zeros, 16 ones, then the IPv4 bits.
  always_comb begin
    if (bit_cnt < MAP_ONES_FIRST) begin
      cur_bit = 1'b0;
    end else if (bit_cnt < MAP_IP_FIRST) begin
      cur_bit = 1'b1;
    end else begin
      cur_bit = ip_sr[31];
    end
  end

  // Record picked at the current node; a node beyond the store reads empty.
  assign rec = st_rsp.oor ? nc32 : pick_record(st_rsp.rdata, record_size_mode, cur_bit);

  // State register and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt  <= bit_cnt_next;
    ip_sr    <= ip_sr_next;
    rec_hold <= rec_hold_next;
    result   <= result_next;
  end

  // Next state, store access and serial adder launch.
  always_comb begin
    state_next    = state;
    bit_cnt_next  = bit_cnt;
    ip_sr_next    = ip_sr;
    rec_hold_next = rec_hold;
    done_next     = 1'b0;
    result_next   = result;
    st_req.we     = 1'b0;
    st_req.waddr  = request.node_index;
    st_req.wdata  = request.node_bytes;
    st_req.raddr  = '0;
    off_req.go    = 1'b0;
    off_req.rec   = rec;
    off_req.addend = leaf_base(num_nodes, record_size_mode);
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (request.op == OP_WRITE) begin
            st_req.we = 1'b1;
          end else begin
            // Root node is read while the beat is taken.
            state_next   = S_WALK;
            bit_cnt_next = '0;
            ip_sr_next   = {request.ip_address[7:0], request.ip_address[15:8],
                            request.ip_address[23:16], request.ip_address[31:24]};
          end
        end
      end
      S_WALK: begin
        if (rec == nc32) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '{status: ST_EMPTY, record_value: '0, data_offset: '0};
        end else if (rec > nc32) begin
          state_next    = S_SUM;
          rec_hold_next = rec;
          off_req.go    = 1'b1;
        end else if (bit_cnt == MAP_LAST_BIT) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '{status: ST_MISS, record_value: '0, data_offset: '0};
        end else begin
          // Record is below the node count, so it fits the read address.
          st_req.raddr = rec[14:0];
          bit_cnt_next = bit_cnt + 7'd1;
          if (bit_cnt >= MAP_IP_FIRST) begin
            ip_sr_next = {ip_sr[30:0], 1'b0};
          end
        end
      end
      S_SUM: begin
        if (off_rsp.done) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '{status: ST_FOUND, record_value: rec_hold,
                          data_offset: off_rsp.sum};
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A lookup beat always starts a walk; a node write never makes the block busy.
  `BTL_ASSERT_NEXT(a_lookup_busy, clk, rst, accept && (request.op == OP_LOOKUP), busy)
  `BTL_ASSERT_NEXT(a_write_idle, clk, rst, accept && (request.op == OP_WRITE), !busy)
  // Only a found leaf carries a record and offset.
  `BTL_ASSERT_NOW(a_miss_zero, clk, rst, done && (result.status != ST_FOUND),
                  (result.record_value == '0) && (result.data_offset == '0))
  // The IPv4 shift register holds while the fixed prefix bits are walked.
  `BTL_ASSERT_NEXT(a_prefix_hold, clk, rst, (state == S_WALK) && (bit_cnt < MAP_IP_FIRST),
                   $stable(ip_sr))
  // A result beat only follows the walk or the offset sum.
  `BTL_ASSERT_NOW(a_done_source, clk, rst, done,
                  ($past(state) == S_WALK) || ($past(state) == S_SUM))

endmodule
`default_nettype wire

// ----- hdl/binary_trie_ip_lookup_top.sv -----
// Top level of the binary trie IP lookup block.
`timescale 1ns / 1ps
`default_nettype none
// Node writes and lookups enter on start while busy is low. A node write
// completes in the cycle it is taken and gives no result. A lookup reads one
// node per cycle through the node store's registered read port, one bit of
// the IPv4-mapped address per read, until an empty record, a data leaf or
// the last address bit ends it; a leaf then runs the bit-serial offset adder.
// Done is high for a single cycle and cannot be stalled; the result port holds
// the result from then until the next result.
// The node store needs no clearing after reset; reading a node that was
// never written gives an undefined result.
module binary_trie_ip_lookup_top #(
  parameter int NODES = 16384
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  btl_pkg::in_item_t   request,
  output logic                done,
  output btl_pkg::out_item_t  result,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire                 cfg_index,
  input  wire [14:0]          cfg_data
);
  import btl_pkg::*;

  logic [1:0]  record_size_mode;
  logic [14:0] num_nodes;
  st_req_t     st_req;
  st_rsp_t     st_rsp;
  off_req_t    off_req;
  off_rsp_t    off_rsp;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_size_mode <= MODE_24;
      num_nodes        <= 15'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RECORD_SIZE: record_size_mode <= cfg_data[1:0];
        REG_NODE_COUNT:  num_nodes        <= cfg_data;
        default: ;
      endcase
    end
  end

  btl_node_store #(
    .NODES(NODES)
  ) u_store (
    .clk(clk),
    .req(st_req),
    .rsp(st_rsp)
  );

  btl_offset_unit u_offset (
    .clk(clk),
    .rst(rst),
    .req(off_req),
    .rsp(off_rsp)
  );

  btl_walker u_walker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .record_size_mode(record_size_mode),
    .num_nodes(num_nodes),
    .st_req(st_req),
    .st_rsp(st_rsp),
    .off_req(off_req),
    .off_rsp(off_rsp),
    .done(done),
    .result(result)
  );

endmodule
`default_nettype wire

// ----- sim/tb_binary_trie_ip_lookup_top.sv -----
// Self-checking testbench for the binary trie IP lookup block.
`timescale 1ns / 1ps

module tb_binary_trie_ip_lookup_top;
  import btl_pkg::*;

  // Keeps a copy of the node store and registers, and checks lookup results in order.
  class trie_lookup_checker #(int DEPTH = 16384);
    logic [63:0] node_mem [DEPTH];
    logic [1:0]  mode_reg;
    logic [14:0] node_total;
    out_item_t   pending_results [$];
    int          mismatches;

    function new();
      mode_reg   = MODE_24;
      node_total = 15'd1;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [14:0] data);
      if (idx == REG_RECORD_SIZE) begin
        mode_reg = data[1:0];
      end else begin
        node_total = data;
      end
    endfunction

    // Left or right record of a node; nodes past the store read as the node count.
    function logic [31:0] read_record(logic [31:0] node, logic right);
      logic [63:0] w;
      if (node >= DEPTH) return {17'd0, node_total};
      w = node_mem[node];
      case (mode_reg)
        MODE_24: return right ? {8'd0, w[39:16]} : {8'd0, w[63:40]};
        MODE_28: return right ? {4'd0, w[35:8]} : {4'd0, w[63:36]};
        default: return right ? w[31:0] : w[63:32];
      endcase
    endfunction

    // Walks the tree along ::ffff:a.b.c.d from the top bit, starting at node 0.
    function out_item_t walk_trie(logic [31:0] ip);
      logic [127:0] mapped;
      logic [31:0]  node, rec, total32;
      out_item_t    res;
      int           node_len, i;
      bit           ended;
      mapped   = {80'd0, 16'hFFFF, ip[7:0], ip[15:8], ip[23:16], ip[31:24]};
      total32  = {17'd0, node_total};
      node_len = (mode_reg == MODE_24) ? 6 : (mode_reg == MODE_28) ? 7 : 8;
      res      = '0;
      res.status = ST_MISS;
      node     = 32'd0;
      ended    = 1'b0;
      for (i = 0; i < 128 && !ended; i++) begin
        rec = read_record(node, mapped[127 - i]);
        if (rec == total32) begin
          res.status = ST_EMPTY;
          ended = 1'b1;
        end else if (rec > total32) begin
          res.status       = ST_FOUND;
          res.record_value = rec;
          res.data_offset  = total32 * node_len + rec - total32;
          ended = 1'b1;
        end else begin
          node = rec;
        end
      end
      return res;
    endfunction

    // Node writes update the store; lookups queue their expected result.
    function void note_request(in_item_t req);
      if (req.op == OP_WRITE) begin
        node_mem[req.node_index] = req.node_bytes;
      end else begin
        pending_results.insert(pending_results.size(), walk_trie(req.ip_address));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no lookup waiting: status %0d record %h offset %h",
                   $realtime, got.status, got.record_value, got.data_offset);
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.record_value !== exp.record_value ||
            got.data_offset !== exp.data_offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: lookup mismatch: exp status %0d record %h offset %h, got %0d %h %h",
                     $realtime, exp.status, exp.record_value, exp.data_offset,
                     got.status, got.record_value, got.data_offset);
        end
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  localparam int STORE_DEPTH = 16384;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    request = '0;
  logic        done;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_RECORD_SIZE;
  logic [14:0] cfg_data = '0;

  trie_lookup_checker #(STORE_DEPTH) trie_chk;

  // Stimulus state: current settings and the nodes of the tree being walked.
  logic [1:0] cur_mode = MODE_24;
  int         cur_count = 1;
  int         term_pct = 15;
  int         tree_nodes [$];
  bit         taken [int];
  bit         shaped;
  int         b_node;
  bit         calm = 1'b0;
  int         item_seq = 0;

  binary_trie_ip_lookup_top #(
    .NODES(STORE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch every handshake at the clock edge and feed the checker.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) trie_chk.check_result(result);
      if (start && !busy) trie_chk.note_request(request);
      if (cfg_valid && cfg_ready) trie_chk.set_register(cfg_index, cfg_data);
    end
  end

  function automatic logic [31:0] record_max();
    case (cur_mode)
      MODE_24: return 32'h00FF_FFFF;
      MODE_28: return 32'h0FFF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Packs two records into the node layout; bytes past the node size get junk.
  function automatic logic [63:0] pack_node(logic [31:0] left, logic [31:0] right);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    case (cur_mode)
      MODE_24: return {left[23:0], right[23:0], junk[15:0]};
      MODE_28: return {left[27:0], right[27:0], junk[7:0]};
      default: return {left, right};
    endcase
  endfunction

  // A record that is a data leaf, the empty marker, a link to a tree node or a link past the store.
  function automatic logic [31:0] pick_record();
    int          r;
    logic [31:0] lo, hi;
    r  = $urandom_range(0, 99);
    lo = cur_count + 1;
    hi = record_max();
    if (r < term_pct / 2) return cur_count;
    if (r < term_pct || cur_count == 0) begin
      case ($urandom_range(0, 3))
        0: return lo;
        1: return hi;
        default: return $urandom_range(lo, hi);
      endcase
    end
    if (cur_count > STORE_DEPTH && $urandom_range(0, 19) == 0)
      return $urandom_range(STORE_DEPTH, cur_count - 1);
    return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
  endfunction

  // Sends one beat after a random gap; start stays high across back-to-back beats.
  task automatic send_item(in_item_t it);
    int gap;
    if (item_seq % 64 == 0) calm = ($urandom_range(0, 2) == 0);
    item_seq++;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_node(int idx, logic [63:0] bytes);
    in_item_t it;
    it.op         = OP_WRITE;
    it.node_index = idx[13:0];
    it.node_bytes = bytes;
    it.ip_address = $urandom();
    send_item(it);
  endtask

  task automatic set_node(int idx, logic [31:0] left, logic [31:0] right);
    put_node(idx, pack_node(left, right));
  endtask

  task automatic look_up(logic [31:0] ip);
    in_item_t it;
    it.op         = OP_LOOKUP;
    it.node_index = 14'($urandom());
    it.node_bytes = {$urandom(), $urandom()};
    it.ip_address = ip;
    send_item(it);
  endtask

  // Holds off the sender until every lookup has answered and the block is idle.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (trie_chk.outstanding() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Leaves valid high so that two writes in a row need no drop in between.
  task automatic write_reg(logic idx, logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [1:0] mode, int count);
    logic [12:0] junk;
    junk = 13'($urandom());
    drain_results();
    write_reg(REG_RECORD_SIZE, {junk, mode});
    write_reg(REG_NODE_COUNT, count[14:0]);
    cfg_valid <= 1'b0;
    cur_mode  = mode;
    cur_count = count;
  endtask

  initial begin
    int          p, k, size, lim, idx;
    logic [31:0] ip;
    trie_chk = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default settings: a zero node loops to a miss, then empty and maximum leaf.
    put_node(0, 64'h0);
    look_up($urandom());
    put_node(STORE_DEPTH - 1, 64'hFFFF_FFFF_FFFF_FFFF);
    set_node(0, 32'd1, 32'h00FF_FFFF);
    look_up(32'h0);
    set_node(0, 32'd0, 32'h00FF_FFFF);
    look_up(32'hFFFF_FFFF);

    // Reserved mode acts as 32-bit records; walks end empty, as a miss and at a leaf.
    set_config(MODE_RESERVED, 2);
    set_node(0, 32'd0, 32'd1);
    set_node(1, 32'd2, 32'd1);
    look_up(32'h0);
    look_up(32'hFFFF_FFFF);
    set_node(1, 32'd2, 32'hFFFF_FFFF);
    look_up(32'h1234_5678);

    // Zero node count: a zero record is empty, anything else is a leaf.
    set_config(MODE_28, 0);
    set_node(0, 32'd0, 32'd5);
    look_up($urandom());
    set_node(0, 32'h0FFF_FFFF, 32'd0);
    look_up($urandom());

    // Node count above the store: links past the store end as empty.
    set_config(MODE_32, 32767);
    set_node(0, 32'd0, 32'd20000);
    look_up($urandom());
    set_node(0, STORE_DEPTH, 32'd0);
    look_up($urandom());

    // Full store with the last node as a self loop on one bits.
    set_config(MODE_24, STORE_DEPTH);
    set_node(0, 32'd0, STORE_DEPTH - 1);
    set_node(STORE_DEPTH - 1, STORE_DEPTH + 1, STORE_DEPTH - 1);
    look_up(32'h0);
    look_up(32'hFFFF_FFFF);

    // Random phases, each with its own settings and a fresh tree.
    for (p = 0; p < 10; p++) begin
      case (p % 5)
        0: set_config(2'(p % 4), $urandom_range(2, 40));
        1: set_config(2'(p % 4), $urandom_range(41, 4000));
        2: set_config(2'(p % 4), STORE_DEPTH);
        3: set_config(2'(p % 4), $urandom_range(STORE_DEPTH + 1, 32767));
        default: set_config(2'(p % 4), $urandom_range(0, 1));
      endcase
      case ($urandom_range(0, 2))
        0: term_pct = 5;
        1: term_pct = 15;
        default: term_pct = 40;
      endcase

      // Pick distinct node indices, node 0 first, the rest inside the node count and the store.
      lim  = (cur_count < STORE_DEPTH) ? cur_count : STORE_DEPTH;
      size = $urandom_range(8, 48);
      tree_nodes.delete();
      taken.delete();
      tree_nodes.insert(tree_nodes.size(), 0);
      taken[0] = 1'b1;
      while (tree_nodes.size() < size && tree_nodes.size() < lim) begin
        idx = $urandom_range(1, lim - 1);
        if (!taken.exists(idx)) begin
          taken[idx] = 1'b1;
          tree_nodes.insert(tree_nodes.size(), idx);
        end
      end

      // Most trees loop node 0 on the zero prefix and a second node on the ones,
      // so that walks reach the IPv4 bits.
      shaped = (tree_nodes.size() >= 2) && ($urandom_range(0, 4) != 0);
      b_node = (tree_nodes.size() >= 2) ? tree_nodes[1] : 0;
      foreach (tree_nodes[k]) begin
        if (shaped && k == 0) set_node(0, 32'd0, b_node);
        else if (shaped && k == 1) set_node(b_node, pick_record(), b_node);
        else set_node(tree_nodes[k], pick_record(), pick_record());
      end

      // Mostly lookups, with node rewrites and an occasional full drain.
      for (k = 0; k < 112; k++) begin
        case ($urandom_range(0, 99)) inside
          [0:11]: begin
            idx = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
            if (shaped && idx == 0 && $urandom_range(0, 3) != 0)
              set_node(0, 32'd0, b_node);
            else if (shaped && idx == b_node && $urandom_range(0, 3) != 0)
              set_node(b_node, pick_record(), b_node);
            else
              set_node(idx, pick_record(), pick_record());
          end
          12: drain_results();
          default: begin
            case ($urandom_range(0, 9))
              0: ip = 32'h0;
              1: ip = 32'hFFFF_FFFF;
              default: ip = $urandom();
            endcase
            look_up(ip);
          end
        endcase
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (trie_chk.mismatches == 0 && trie_chk.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- binary_trie_ip_lookup_top.f -----
+incdir+hdl
hdl/btl_pkg.sv
hdl/btl_node_store.sv
hdl/btl_offset_unit.sv
hdl/btl_walker.sv
hdl/binary_trie_ip_lookup_top.sv
sim/tb_binary_trie_ip_lookup_top.sv
